// ===== rtl/core/twma_pkg.sv =====
// Shared types, field widths and codes for the time-window moving average.
`default_nettype none

package twma_pkg;

  localparam int VALUE_W   = 32;
  localparam int TIME_W    = 48;
  localparam int WIN_W     = 32;
  localparam int RES_W     = 38;
  localparam int HELD_W    = 7;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;
  localparam int DEPTH_DEF = 64;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1000);
  localparam logic             AVG_RESET = 1'b1;

  // item commands
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_WRITE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic rd_oldest;
    logic pop;
    logic wr_new;
    logic div_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic new_is_report;
    logic expired;
    logic full;
    logic nonempty;
    logic avg_mode;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/time_window_moving_average.sv =====
// Top level of the time-window moving average.
`default_nettype none

// Holds up to DEPTH timestamped signed samples in a ring memory. An add item
// evicts, oldest first, entries whose time plus window_length lies before the
// new time, stopping at the first live entry, drops the oldest if the ring is
// still full, then stores the sample; a report item changes nothing. Each item
// yields one result: the sum of held values, or in average mode the average
// truncated toward zero (0 when empty), plus the entry count. Items are handled
// one at a time. An add does one memory read and compare per entry it checks;
// in average mode a nonempty result also waits for the serial divider.
// A result waits in the output register while the next item is taken; a
// stalled result holds the following one back until the register frees.
// Config writes are always ready.

module time_window_moving_average #(
  parameter int DEPTH = twma_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [twma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twma_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [twma_pkg::VALUE_W-1:0] in_sample_value,
  input  logic [twma_pkg::TIME_W-1:0]         in_sample_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [twma_pkg::RES_W-1:0]   out_window_result,
  output logic [twma_pkg::HELD_W-1:0]         out_entries_held
);

  import twma_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  twma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  twma_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_command        (in_command),
    .in_sample_value   (in_sample_value),
    .in_sample_time    (in_sample_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_result (out_window_result),
    .out_entries_held  (out_entries_held)
  );

endmodule

`default_nettype wire

// ===== rtl/core/twma_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module twma_div #(
  parameter int DIVIDEND_W = 39,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  localparam int ITER_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quot_r, quot_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [ITER_W-1:0]     iter_r, iter_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;

  assign rem_sh   = {rem_r, quot_r[DIVIDEND_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    iter_nxt = iter_r;
    if (load) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      iter_nxt = ITER_W'(DIVIDEND_W);
    end else if (iter_r != '0) begin
      iter_nxt = iter_r - 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        // remainder stays below the divisor, so the top bit is always clear
        rem_nxt  = rem_diff[DIVISOR_W-1:0];
        quot_nxt = {quot_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[DIVISOR_W-1:0];
        quot_nxt = {quot_r[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else begin
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign quotient = quot_r;
  assign done     = (iter_r == '0);

endmodule

`default_nettype wire

// ===== rtl/core/twma_dp.sv =====
// Datapath: sample ring, running sum, divider, config and result registers.
`default_nettype none

module twma_dp #(
  parameter int DEPTH = twma_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  twma_pkg::ctrl_cmd_t                   cmd,
  output twma_pkg::ctrl_sts_t                   sts,
  input  logic                                  cfg_we,
  input  logic [twma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [twma_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                  in_command,
  input  logic signed [twma_pkg::VALUE_W-1:0]   in_sample_value,
  input  logic [twma_pkg::TIME_W-1:0]           in_sample_time,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [twma_pkg::RES_W-1:0]     out_window_result,
  output logic [twma_pkg::HELD_W-1:0]           out_entries_held
);

  import twma_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = VALUE_W + 1 + $clog2(DEPTH);
  localparam int EXT_W = (SUM_W > RES_W) ? SUM_W : RES_W;
  localparam int HC_W  = (CNT_W > HELD_W) ? CNT_W : HELD_W;

  localparam logic signed [EXT_W-1:0] SAT_HI =
    {{(EXT_W - RES_W + 1){1'b0}}, {(RES_W - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_LO =
    {{(EXT_W - RES_W + 1){1'b1}}, {(RES_W - 1){1'b0}}};
  localparam logic [HC_W-1:0] HELD_MAX = {HC_W{1'b0}} | {HELD_W{1'b1}};

  // sample ring
  logic signed [VALUE_W-1:0] value_mem [DEPTH];
  logic [TIME_W-1:0]         time_mem  [DEPTH];

  logic signed [VALUE_W-1:0] rd_value_r;
  logic [TIME_W-1:0]         rd_time_r;

  logic                      in_cmd_r;
  logic signed [VALUE_W-1:0] in_value_r;
  logic [TIME_W-1:0]         in_time_r;

  logic [WIN_W-1:0]          window_r, window_nxt;
  logic                      avg_r, avg_nxt;

  logic [PTR_W-1:0]          oldest_r, oldest_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;

  logic [CNT_W:0]            slot_sum;
  logic [PTR_W-1:0]          slot;
  logic [TIME_W:0]           expiry;

  logic [SUM_W-1:0]          sum_abs;
  logic [SUM_W-1:0]          quotient;
  logic                      div_done;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0]   out_result_r;
  logic [HELD_W-1:0]         out_held_r;
  logic signed [EXT_W-1:0]   res_ext;
  logic signed [EXT_W-1:0]   quot_ext;
  logic [HC_W-1:0]           cnt_ext;

  // config registers
  always_comb begin
    window_nxt = window_r;
    avg_nxt    = avg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_nxt = cfg_data[WIN_W-1:0];
        REG_AVERAGE_MODE:  avg_nxt    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
      avg_r    <= AVG_RESET;
    end else begin
      window_r <= window_nxt;
      avg_r    <= avg_nxt;
    end
  end

  // input item latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_cmd_r   <= in_command;
      in_value_r <= in_sample_value;
      in_time_r  <= in_sample_time;
    end
  end

  // ring slot for the new sample, wraps for any depth
  assign slot_sum = {1'b0, (CNT_W)'(oldest_r)} + {1'b0, count_r};
  always_comb begin
    if (slot_sum >= (CNT_W + 1)'(DEPTH)) begin
      slot = PTR_W'(slot_sum - (CNT_W + 1)'(DEPTH));
    end else begin
      slot = slot_sum[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      value_mem[slot] <= in_value_r;
      time_mem[slot]  <= in_time_r;
    end
    if (cmd.rd_oldest) begin
      rd_value_r <= value_mem[oldest_r];
      rd_time_r  <= time_mem[oldest_r];
    end
  end

  // ring bookkeeping
  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    if (cmd.pop) begin
      oldest_nxt = (oldest_r == PTR_W'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
      count_nxt  = count_r - 1'b1;
      sum_nxt    = sum_r - SUM_W'(rd_value_r);
    end else if (cmd.wr_new) begin
      count_nxt  = count_r + 1'b1;
      sum_nxt    = sum_r + SUM_W'(in_value_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      sum_r    <= '0;
    end else begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
    end
  end

  assign expiry = {1'b0, rd_time_r} + (TIME_W + 1)'(window_r);

  // division of the sum magnitude by the entry count
  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  twma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.div_load),
    .dividend (sum_abs),
    .divisor  (count_r),
    .quotient (quotient),
    .done     (div_done)
  );

  // result formation and saturation
  assign quot_ext = sum_r[SUM_W-1] ? -$signed(EXT_W'(quotient)) : $signed(EXT_W'(quotient));

  always_comb begin
    if (count_r == '0) begin
      res_ext = '0;
    end else if (avg_r) begin
      res_ext = quot_ext;
    end else begin
      res_ext = EXT_W'(sum_r);
    end
    if (res_ext > SAT_HI) begin
      res_ext = SAT_HI;
    end else if (res_ext < SAT_LO) begin
      res_ext = SAT_LO;
    end
  end

  assign cnt_ext = HC_W'(count_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_r <= res_ext[RES_W-1:0];
      out_held_r   <= (cnt_ext > HELD_MAX) ? HELD_MAX[HELD_W-1:0] : cnt_ext[HELD_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_window_result = out_result_r;
  assign out_entries_held  = out_held_r;

  always_comb begin
    sts.new_is_report = (in_command == CMD_REPORT);
    sts.nonempty      = (count_r != '0);
    sts.expired       = (count_r != '0) && (expiry < {1'b0, in_time_r});
    sts.full          = (count_r == CNT_W'(DEPTH));
    sts.avg_mode      = avg_r;
    sts.div_done      = div_done;
    sts.out_free      = !out_valid_r || !out_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above ring depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0)
    else $error("pop from empty ring");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |-> count_r < CNT_W'(DEPTH))
    else $error("write into full ring");

  // a report item must leave the ring alone
  a_report_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_new || cmd.pop) |-> (in_cmd_r == CMD_ADD))
    else $error("ring changed by a report item");

  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> div_done)
    else $error("result loaded while divider busy");

endmodule

`default_nettype wire

// ===== rtl/core/twma_ctrl.sv =====
// Controller: sequences eviction, insert, division and result hand-off.
`default_nettype none

module twma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  twma_pkg::ctrl_sts_t sts,
  output twma_pkg::ctrl_cmd_t cmd
);

  import twma_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.new_is_report ? ST_DIV_LOAD : ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = sts.expired ? ST_READ : ST_WRITE;
      ST_WRITE: state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: begin
        state_nxt = (sts.avg_mode && sts.nonempty) ? ST_DIV_RUN : ST_FINISH;
      end
      ST_DIV_RUN: begin
        if (sts.div_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      ST_READ:     cmd.rd_oldest = 1'b1;
      // oldest entry goes if expired, or to make room in a full ring
      ST_CHECK:    cmd.pop       = sts.expired || sts.full;
      ST_WRITE:    cmd.wr_new    = 1'b1;
      ST_DIV_LOAD: cmd.div_load  = sts.avg_mode && sts.nonempty;
      ST_DIV_RUN:  ;
      ST_FINISH:   cmd.out_load  = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== verif/twma_window_checker.sv =====
// Result checker for the time-window moving average: predicts each item's result and compares.
`timescale 1ns / 100ps

module twma_window_checker #(
  parameter int DEPTH = twma_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [twma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twma_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_command,
  input  logic signed [twma_pkg::VALUE_W-1:0] in_sample_value,
  input  logic [twma_pkg::TIME_W-1:0]         in_sample_time,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [twma_pkg::RES_W-1:0]   out_window_result,
  input  logic [twma_pkg::HELD_W-1:0]         out_entries_held,
  output int                                  mismatches,
  output int                                  results_pending,
  output int                                  expiry_pops,
  output int                                  full_pops
);

  import twma_pkg::*;

  localparam longint      RES_HI   = (longint'(1) <<< (RES_W - 1)) - 1;
  localparam longint      RES_LO   = -RES_HI - 1;
  localparam int unsigned HELD_TOP = (1 << HELD_W) - 1;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [HELD_W-1:0]       held;
  } window_result_t;

  // own copy of the ring and the registers
  logic signed [VALUE_W-1:0] held_value [DEPTH];
  logic [TIME_W-1:0]         held_time  [DEPTH];
  int unsigned               oldest;
  int unsigned               count;
  longint                    window_sum;
  logic [WIN_W-1:0]          span;
  logic                      avg_on;

  window_result_t expected_results [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic drop_oldest();
    window_sum -= longint'(held_value[oldest]);
    oldest = (oldest + 1) % DEPTH;
    count--;
  endtask

  task automatic apply_item(input logic cmd, input logic signed [VALUE_W-1:0] value,
                            input logic [TIME_W-1:0] stamp, output window_result_t res);
    longint acc;
    int unsigned slot;
    if (cmd == CMD_ADD) begin
      // stops at the first live entry, even if newer ones behind it are stale
      while (count > 0 && 64'(held_time[oldest]) + 64'(span) < 64'(stamp)) begin
        drop_oldest();
        expiry_pops++;
      end
      if (count >= DEPTH) begin
        drop_oldest();
        full_pops++;
      end
      slot = (oldest + count) % DEPTH;
      held_value[slot] = value;
      held_time[slot] = stamp;
      count++;
      window_sum += longint'(value);
    end
    acc = 0;
    // signed division truncates toward zero; deep rings clip to the result range
    if (count > 0) acc = avg_on ? window_sum / longint'(count) : window_sum;
    if (acc > RES_HI) acc = RES_HI;
    else if (acc < RES_LO) acc = RES_LO;
    res.result = acc[RES_W-1:0];
    res.held = (count > HELD_TOP) ? '1 : count[HELD_W-1:0];
  endtask

  always @(posedge clk) begin
    window_result_t want;
    window_result_t fresh;
    if (!rst_n) begin
      oldest = 0;
      count = 0;
      window_sum = 0;
      span = WIN_RESET;
      avg_on = AVG_RESET;
      expected_results.delete();
      mismatches = 0;
      expiry_pops = 0;
      full_pops = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", longint'(out_window_result), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_window_result !== want.result)
            report_mismatch("window_result", longint'(out_window_result),
                            longint'(want.result));
          if (out_entries_held !== want.held)
            report_mismatch("entries_held", longint'(out_entries_held), longint'(want.held));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_LENGTH) span = cfg_data[WIN_W-1:0];
        else if (cfg_index == REG_AVERAGE_MODE) avg_on = cfg_data[0];
      end
      if (in_valid && !in_stall) begin
        apply_item(in_command, in_sample_value, in_sample_time, fresh);
        expected_results.push_back(fresh);
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Stimulus, idling and verdict for the time-window moving average.
`timescale 1ns / 100ps

module testbench;

  import twma_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 240;
  localparam int LONG_HOLD     = 400;
  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 200;

  localparam logic [CFG_IDX_W-1:0]      REG_UNMAPPED = CFG_IDX_W'(15);
  localparam logic signed [VALUE_W-1:0] VALUE_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN    = 32'sh8000_0000;
  localparam logic [TIME_W-1:0]         TIME_LAST    = '1;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DAT_W-1:0]       cfg_data;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_command;
  logic signed [VALUE_W-1:0]  in_sample_value;
  logic [TIME_W-1:0]          in_sample_time;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [RES_W-1:0]    out_window_result;
  logic [HELD_W-1:0]          out_entries_held;

  int mismatches;
  int results_pending;
  int expiry_pops;
  int full_pops;

  bit               hold_request;
  bit               quiet_phase;
  int               adds_sent;
  int               reports_sent;
  int               settings_used;
  int               idle_cycles;
  int               step_shift;
  logic [WIN_W-1:0] cur_span = WIN_RESET;
  logic [TIME_W-1:0] now_stamp;

  time_window_moving_average #(.DEPTH(DEPTH_DEF)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_sample_value   (in_sample_value),
    .in_sample_time    (in_sample_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_result (out_window_result),
    .out_entries_held  (out_entries_held)
  );

  twma_window_checker #(.DEPTH(DEPTH_DEF)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_sample_value   (in_sample_value),
    .in_sample_time    (in_sample_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_result (out_window_result),
    .out_entries_held  (out_entries_held),
    .mismatches        (mismatches),
    .results_pending   (results_pending),
    .expiry_pops       (expiry_pops),
    .full_pops         (full_pops)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic longint unsigned rand_upto(input longint unsigned bound);
    return {$urandom, $urandom} % (bound + 1);
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] prev);
    longint unsigned span64;
    longint unsigned t;
    int pick;
    span64 = 64'(cur_span);
    t = 64'(prev);
    pick = $urandom_range(0, 99);
    // below 15 the stamp repeats
    if (pick >= 15 && pick < 78) t += rand_upto((span64 >> step_shift) + 2);
    else if (pick >= 78 && pick < 92) t += span64 / 2 + rand_upto(span64 + 2);
    else if (pick >= 92 && pick < 96) t += span64 * 3 + rand_upto(64'hFFFF);
    else if (pick >= 96) t = (t > span64 + 100) ? t - rand_upto(span64 + 100) : 0;
    if (t > 64'(TIME_LAST)) t = 64'(TIME_LAST);
    return t[TIME_W-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3:    return VALUE_W'($urandom_range(0, 200) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic cmd, input logic signed [VALUE_W-1:0] value,
                             input logic [TIME_W-1:0] stamp);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample_value <= value;
    in_sample_time <= stamp;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_ADD) adds_sent++;
    else reports_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = (quiet_phase || hold_request) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // registers change only once every pending result is out
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) begin
      cur_span = data[WIN_W-1:0];
      settings_used++;
    end
  endtask

  // receiver: random stalls, one long hold on request, none in a quiet phase
  initial begin
    int run_len;
    int stall_len;
    out_stall <= 1'b0;
    forever begin
      run_len = $urandom_range(1, 30);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet_phase) begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [WIN_W-1:0] span_pick;
    logic             avg_pick;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_command <= CMD_ADD;
    in_sample_value <= '0;
    in_sample_time <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty window, value extremes, expiry at the boundary
    send_sample(CMD_REPORT, VALUE_MIN, TIME_LAST);
    send_sample(CMD_ADD, VALUE_MAX, 0);
    send_sample(CMD_ADD, VALUE_MIN, 0);
    send_sample(CMD_ADD, -7, 1000);
    send_sample(CMD_ADD, 3, 1001);
    send_sample(CMD_REPORT, VALUE_MAX, 0);
    // out-of-order stamps: the stale middle entry survives behind a live oldest
    send_sample(CMD_ADD, 5, 5000);
    send_sample(CMD_ADD, -6, 100);
    send_sample(CMD_ADD, 7, 5900);
    send_sample(CMD_ADD, -9, 6500);
    send_sample(CMD_ADD, 1, TIME_LAST);
    write_register(REG_AVERAGE_MODE, CFG_DAT_W'(0));
    write_register(REG_WINDOW_LENGTH, CFG_DAT_W'(0));
    // zero window: equal and lower stamps stay behind a live oldest entry
    send_sample(CMD_ADD, 10, 20);
    send_sample(CMD_ADD, -11, 20);
    send_sample(CMD_ADD, 12, 21);
    write_register(REG_UNMAPPED, '1);
    send_sample(CMD_REPORT, -1, 48'h5555_5555_5555);
    write_register(REG_WINDOW_LENGTH, '1);
    send_sample(CMD_ADD, VALUE_MIN, 0);
    send_sample(CMD_ADD, VALUE_MIN, TIME_LAST);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin span_pick = WIN_W'(1000); avg_pick = 1'b1; end
        1:       begin span_pick = '0;           avg_pick = 1'b0; end
        2:       begin span_pick = WIN_W'(1);    avg_pick = 1'b1; end
        3:       begin span_pick = '1;           avg_pick = 1'b0; end
        4:       begin span_pick = '1;           avg_pick = 1'b1; end
        5:       begin span_pick = $urandom_range(2, 300); avg_pick = 1'($urandom); end
        6:       begin span_pick = $urandom;     avg_pick = 1'($urandom); end
        default: begin span_pick = $urandom_range(1000, 100000); avg_pick = 1'b1; end
      endcase
      write_register(REG_WINDOW_LENGTH, span_pick);
      write_register(REG_AVERAGE_MODE, CFG_DAT_W'(avg_pick));
      step_shift = $urandom_range(2, 9);
      now_stamp = TIME_W'({$urandom, $urandom}) >> $urandom_range(0, 16);
      quiet_phase = (ph == 2);
      // long receiver hold while the sender keeps offering, to back the block up
      hold_request = (ph == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 80) begin
          now_stamp = next_stamp(now_stamp);
          send_sample(CMD_ADD, pick_value(), now_stamp);
        end else begin
          send_sample(CMD_REPORT, $urandom, TIME_W'({$urandom, $urandom}));
        end
        pause_sender();
      end
    end
    quiet_phase = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d adds and %0d reports across %0d window lengths.",
             adds_sent + reports_sent, adds_sent, reports_sent, settings_used);
    $display("The window expired %0d entries and dropped %0d from a full ring.",
             expiry_pops, full_pops);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
